FILE: hw/rtl/wcs_pkg.sv
// Shared types and constants for the write completion scoreboard.
package wcs_pkg;

	// Fixed widths of the transaction fields
	localparam int SEQ_W    = 32;
	localparam int CREDIT_W = 7;
	localparam int STATUS_W = 3;

	// Credit limit after reset and the hard ceiling on credits
	localparam int CREDIT_RESET = 32;
	localparam int CREDIT_CAP   = 64;

	typedef enum logic {
		OP_ISSUE = 1'b0,
		OP_REPLY = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 3'd0,
		ST_NO_CREDIT     = 3'd1,
		ST_DUP_BUSY      = 3'd2,
		ST_UNEXPECTED    = 3'd3,
		ST_ERROR_REPLY   = 3'd4,
		ST_STICKY_REFUSE = 3'd5
	} status_t;

	// Input transaction
	typedef struct packed {
		opcode_t          opcode;
		logic [SEQ_W-1:0] reply_sequence;
		logic             reply_apply;
		logic             reply_commit;
		logic             reply_error;
	} in_t;

	// Result transaction
	typedef struct packed {
		status_t             status;
		logic                granted;
		logic [SEQ_W-1:0]    sequence_out;
		logic                credit_returned;
		logic                entry_done;
		logic [CREDIT_W-1:0] credits_in_use;
		logic                error_latched;
	} out_t;

	// Pending flags: bit 0 apply, bit 1 commit
	typedef struct packed {
		logic             valid;
		logic [1:0]       pending;
		logic [SEQ_W-1:0] tag;
	} entry_t;

endpackage

FILE: hw/rtl/wcs_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
module wcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Storage array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; a same-cycle write to the address returns old data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/write_completion_scoreboard.sv
// Write completion scoreboard: credit-limited tracking of outstanding write requests.
//
// Accepts one transaction per cycle while results are taken, and returns exactly one result
// for each: the slot table read and the stage 1 load share the accepting edge, and the result
// register loads when stage 1 fires. A result waiting on out_ready holds the
// transaction behind it in stage 1 and stalls the input. The slot table is one RAM
// of TABLE_DEPTH entries with a registered read port; a write from the previous
// transaction to the same slot is forwarded. After reset a clearing pass walks the table
// one entry a cycle, so in_ready stays low until every entry is cleared; credit_limit
// writes are taken at any time. TABLE_DEPTH must be a power of two; the slot is the low
// bits of the sequence number.
module write_completion_scoreboard #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  wcs_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output wcs_pkg::out_t                   out_data,
	input  logic                            cfg_we,
	input  logic [wcs_pkg::CREDIT_W-1:0]    cfg_wdata
);

	import wcs_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int EW = $bits(entry_t);

	// State
	logic [CREDIT_W-1:0] credit_limit_q;
	logic [SEQ_W-1:0]    next_seq_q;
	logic [CREDIT_W-1:0] in_flight_q;
	logic                sticky_error_q;
	logic                clr_active_q;
	logic [IW-1:0]       clr_idx_q;

	// Stage 1 (table read) and result register
	logic                item_vld_s1;
	in_t                 item_s1;
	logic [IW-1:0]       slot_s1;
	logic                fwd_hit_s1;
	entry_t              fwd_entry_s1;
	logic                out_vld_q;
	out_t                out_data_q;

	// Handshake and table access
	logic                accept;
	logic                s1_fire;
	logic [IW-1:0]       rd_slot;
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	entry_t              ram_wentry;
	logic [EW-1:0]       ram_rdata;

	// Stage 1 decision
	entry_t              entry;
	logic [CREDIT_W-1:0] eff_limit;
	logic                grant;
	logic                credit;
	logic                tbl_we;
	entry_t              tbl_entry;
	logic [1:0]          matched;
	logic [1:0]          pending_nxt;
	logic                sticky_nxt;
	logic [CREDIT_W-1:0] in_flight_nxt;
	out_t                res;

	assign s1_fire  = item_vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !clr_active_q && (!item_vld_s1 || s1_fire);
	assign accept   = in_valid && in_ready;

	// Slot of the arriving transaction; an issue follows a grant now leaving stage 1
	always_comb begin
		if (in_data.opcode == OP_ISSUE) begin
			rd_slot = next_seq_q[IW-1:0] + IW'(s1_fire && grant);
		end else begin
			rd_slot = in_data.reply_sequence[IW-1:0];
		end
	end

	// Table write port: clearing pass or stage 1 update
	always_comb begin
		if (clr_active_q) begin
			ram_we     = 1'b1;
			ram_waddr  = clr_idx_q;
			ram_wentry = '0;
		end else begin
			ram_we     = s1_fire && tbl_we;
			ram_waddr  = slot_s1;
			ram_wentry = tbl_entry;
		end
	end

	wcs_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.re    (accept),
		.raddr (rd_slot),
		.rdata (ram_rdata)
	);

	// Entry seen by stage 1, with forwarding of the write made at its read
	assign entry     = fwd_hit_s1 ? fwd_entry_s1 : entry_t'(ram_rdata);
	assign eff_limit = (credit_limit_q > CREDIT_W'(CREDIT_CAP)) ?
		CREDIT_W'(CREDIT_CAP) : credit_limit_q;

	// Issue / reply evaluation
	always_comb begin
		grant         = 1'b0;
		credit        = 1'b0;
		tbl_we        = 1'b0;
		tbl_entry     = entry;
		matched       = '0;
		pending_nxt   = entry.pending;
		sticky_nxt    = sticky_error_q;
		in_flight_nxt = in_flight_q;
		res           = '0;
		res.status    = ST_OK;

		if (item_s1.opcode == OP_ISSUE) begin
			res.sequence_out = next_seq_q;
			if (sticky_error_q) begin
				res.status = ST_STICKY_REFUSE;
			end else if (in_flight_q >= eff_limit) begin
				res.status = ST_NO_CREDIT;
			end else if (entry.valid) begin
				res.status = ST_DUP_BUSY;
			end else begin
				grant             = 1'b1;
				tbl_we            = 1'b1;
				tbl_entry.valid   = 1'b1;
				tbl_entry.pending = 2'b11;
				tbl_entry.tag     = next_seq_q;
				in_flight_nxt     = in_flight_q + CREDIT_W'(1);
			end
		end else if (item_s1.reply_error) begin
			res.sequence_out = item_s1.reply_sequence;
			res.status       = ST_ERROR_REPLY;
			sticky_nxt       = 1'b1;
			credit           = (in_flight_q != '0);
		end else begin
			res.sequence_out = item_s1.reply_sequence;
			if (!entry.valid || entry.tag != item_s1.reply_sequence) begin
				res.status = ST_UNEXPECTED;
			end else begin
				matched           = entry.pending &
					{item_s1.reply_commit, item_s1.reply_apply};
				credit            = matched[0] && (in_flight_q != '0);
				pending_nxt       = entry.pending & ~matched;
				tbl_we            = 1'b1;
				tbl_entry.pending = pending_nxt;
				tbl_entry.valid   = (pending_nxt != 2'b00);
				res.entry_done    = (pending_nxt == 2'b00);
			end
		end

		if (credit) begin
			in_flight_nxt = in_flight_q - CREDIT_W'(1);
		end

		res.granted         = grant;
		res.credit_returned = credit;
		res.credits_in_use  = in_flight_nxt;
		res.error_latched   = sticky_nxt;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_limit_q <= CREDIT_W'(CREDIT_RESET);
		end else if (cfg_we) begin
			credit_limit_q <= cfg_wdata;
		end
	end

	// Clearing pass over the slot table after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			clr_idx_q <= clr_idx_q + IW'(1);
			if (clr_idx_q == IW'(TABLE_DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// Scoreboard counters and sticky error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q     <= '0;
			in_flight_q    <= '0;
			sticky_error_q <= 1'b0;
		end else if (s1_fire) begin
			next_seq_q     <= next_seq_q + SEQ_W'(grant);
			in_flight_q    <= in_flight_nxt;
			sticky_error_q <= sticky_nxt;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (accept) begin
			item_vld_s1 <= 1'b1;
		end else if (s1_fire) begin
			item_vld_s1 <= 1'b0;
		end
	end

	// Stage 1 payload and forwarding capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1      <= in_data;
			slot_s1      <= rd_slot;
			fwd_hit_s1   <= ram_we && (ram_waddr == rd_slot);
			fwd_entry_s1 <= ram_wentry;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_fire) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

	// Credits held never exceed the hard ceiling
	a_credit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= CREDIT_W'(CREDIT_CAP))
		else $error("credits in use above ceiling");

	// Sticky error only clears through reset
	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(sticky_error_q))
		else $error("sticky error dropped");

	// A grant advances the sequence by exactly one
	a_seq_advance: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && grant |=> next_seq_q == $past(next_seq_q) + SEQ_W'(1))
		else $error("sequence did not advance on grant");

	// A granted result always holds at least one credit
	a_grant_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_data_q.granted |-> out_data_q.credits_in_use != '0)
		else $error("grant reported with no credit held");

	// Entry completion only comes from a clean reply
	a_done_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_data_q.entry_done |->
		out_data_q.status == ST_OK && !out_data_q.granted)
		else $error("entry done on a non-reply result");

	// No transaction enters while the table is being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !item_vld_s1 && !out_vld_q)
		else $error("transaction in flight during table clear");

endmodule
